// ===== rtl/lmd_pkg.sv =====
// Shared types and constants of the 3x3 local-maximum detector.
// No dependencies; every other file of the block but lmd_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lmd_pkg;

    // Sizes of the sample path and the line stores
    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int FW_W        = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Result queue
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Accepted sample on its way to the window (registered in the cycle after accept)
    typedef struct packed {
        logic             vld;
        logic             judge;
        logic             fend;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_sample          sample;
    } t_s1;

    // Outcome of one window evaluation
    typedef struct packed {
        logic             vld;
        logic             peak;
        logic             fend;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_sample          value;
    } t_judge;

    // One result item
    typedef struct packed {
        logic             is_point;
        logic [ROW_W-1:0] point_row;
        logic [COL_W-1:0] point_col;
        t_sample          point_value;
        logic             frame_done;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lmd_if.sv =====
// Request channels of the detector: sample input, result output, configuration.
// Depends on lmd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lmd_in_if import lmd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface lmd_out_if import lmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             is_point;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
    t_sample          point_value;
    logic             frame_done;

    modport source (output valid, output is_point, output point_row, output point_col,
                    output point_value, output frame_done, input ready);
    modport sink   (input valid, input is_point, input point_row, input point_col,
                    input point_value, input frame_done, output ready);
endinterface

interface lmd_cfg_if import lmd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lmd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lmd_window.sv =====
// 3x3 window: shifts in the column read from the line stores and judges the center.
// Depends on lmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmd_window import lmd_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_s1     i_s1,
    input  wire t_sample i_top,
    input  wire t_sample i_mid,
    output t_judge       o_judge
);

    // Two stored columns: left (oldest) and middle; index 0 top, 2 bottom
    t_sample r_left [3];
    t_sample r_midc [3];
    t_judge  r_judge;

    t_sample new_col [3];
    t_sample center;
    logic    no_greater;

    always_comb begin
        new_col[0] = i_top;
        new_col[1] = i_mid;
        new_col[2] = i_s1.sample;
        center     = r_midc[1];
        no_greater = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_left[k] > center || r_midc[k] > center || new_col[k] > center) begin
                no_greater = 1'b0;
            end
        end
    end

    // Shift the window one column on each sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_left[k] <= '0;
                r_midc[k] <= '0;
            end
        end else if (i_s1.vld) begin
            for (int k = 0; k < 3; k++) begin
                r_left[k] <= r_midc[k];
                r_midc[k] <= new_col[k];
            end
        end
    end

    // Register the verdict for the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_judge.vld <= 1'b0;
        end else begin
            r_judge.vld <= i_s1.vld;
        end
        r_judge.peak  <= i_s1.judge && no_greater && (center != '0);
        r_judge.fend  <= i_s1.fend;
        r_judge.row   <= i_s1.row - ROW_W'(1);
        r_judge.col   <= i_s1.col - COL_W'(1);
        r_judge.value <= center;
    end

    assign o_judge = r_judge;

endmodule

`default_nettype wire

// ===== rtl/lmd_result_queue.sv =====
// Result queue: takes a peak report and/or an end-of-frame marker per sample
// and drains one result per request. Depends on lmd_pkg and lmd_if.
`timescale 1ns / 1ps
`default_nettype none

module lmd_result_queue import lmd_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_judge      i_judge,
    lmd_out_if.source        o_out,
    output logic [Q_CW-1:0]  o_level
);

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, n_wp;
    logic [Q_AW-1:0]  r_rp, n_rp;
    logic [Q_CW-1:0]  r_cnt, n_cnt;

    logic             has_pk;
    logic             has_fe;
    logic             pop;
    logic [Q_AW-1:0]  fe_addr;
    t_result          pk_entry;
    t_result          fe_entry;
    t_result          head;

    always_comb begin
        has_pk  = i_judge.vld && i_judge.peak;
        has_fe  = i_judge.vld && i_judge.fend;
        pop     = o_out.valid && o_out.ready;
        fe_addr = has_pk ? r_wp + Q_AW'(1) : r_wp;

        pk_entry.is_point    = 1'b1;
        pk_entry.point_row   = i_judge.row;
        pk_entry.point_col   = i_judge.col;
        pk_entry.point_value = i_judge.value;
        pk_entry.frame_done  = 1'b0;
        fe_entry             = '0;
        fe_entry.frame_done  = 1'b1;

        n_wp  = r_wp + Q_AW'(has_pk) + Q_AW'(has_fe);
        n_rp  = r_rp + Q_AW'(pop);
        n_cnt = r_cnt + Q_CW'(has_pk) + Q_CW'(has_fe) - Q_CW'(pop);
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (has_pk) begin
            r_mem[r_wp] <= pk_entry;
        end
        if (has_fe) begin
            r_mem[fe_addr] <= fe_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Present the head entry
    assign head              = r_mem[r_rp];
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.is_point    = head.is_point;
    assign o_out.point_row   = head.point_row;
    assign o_out.point_col   = head.point_col;
    assign o_out.point_value = head.point_value;
    assign o_out.frame_done  = head.frame_done;
    assign o_level           = r_cnt;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt + Q_CW'(has_pk) + Q_CW'(has_fe)) <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

// ===== rtl/local_maximum_3x3_detector_unit.sv =====
// Top level of the 3x3 local-maximum detector: counters, configuration,
// line stores, window and result queue. Depends on lmd_pkg, lmd_if, lmd_ram,
// lmd_window and lmd_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one sample per clock in raster order and reports each interior pixel
// that no 3x3 neighbor exceeds (ties count) and that is nonzero, as row, column
// and value; the last sample of a frame also yields an end-of-frame marker.
// Pixel (r,c) is reported when sample (r+1,c+1) is accepted; its result passes
// r_s1, r_judge and the queue memory to the head. The sustained rate is one
// sample per clock, set by the line-store read/write-back (one read and one
// write per clock on each of the two row RAMs). The output drains one result per
// clock while ready is high, so a frame-end sample with both a peak and the
// marker yields two results; the input stalls only when the eight-entry result
// queue cannot absorb the samples in flight. No clearing pass is needed after
// reset. frame_width is clamped to 3..1024 and frame_height to at least 3.
module local_maximum_3x3_detector_unit import lmd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lmd_in_if.sink     i_in,
    lmd_cfg_if.sink    i_cfg,
    lmd_out_if.source  o_out
);

    logic [COL_W-1:0] r_wlast;
    logic [ROW_W-1:0] r_hlast;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_s1              r_s1;

    logic             in_acc;
    logic             row_end;
    logic             frame_end;
    t_sample          top_rd;
    t_sample          mid_rd;
    t_judge           judge;
    logic [Q_CW-1:0]  level;
    logic [1:0]       inflight;
    logic [Q_CW:0]    need;

    // Clamp the written width to 3..MAX_WIDTH and keep the last column index
    function automatic logic [COL_W-1:0] width_last(input logic [FW_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v < FW_W'(3)) begin
            res = COL_W'(2);
        end else if (v > FW_W'(MAX_WIDTH)) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(v - FW_W'(1));
        end
        return res;
    endfunction

    // Clamp the written height to at least 3 and keep the last row index
    function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v < ROW_W'(3)) begin
            res = ROW_W'(2);
        end else begin
            res = v - ROW_W'(1);
        end
        return res;
    endfunction

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= COL_W'(MAX_WIDTH - 1);
            r_hlast <= ROW_W'(1023);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRAME_WIDTH: begin
                    r_wlast <= width_last(i_cfg.data[FW_W-1:0]);
                end
                CFG_FRAME_HEIGHT: begin
                    r_hlast <= height_last(i_cfg.data[ROW_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Admit a sample only when the queue can hold all results in flight
    assign inflight   = 2'(r_s1.vld) + 2'(judge.vld);
    assign need       = {1'b0, level} + (Q_CW + 1)'({inflight, 1'b0}) + (Q_CW + 1)'(2);
    assign i_in.ready = (need <= (Q_CW + 1)'(Q_DEPTH));
    assign in_acc     = i_in.valid && i_in.ready;

    // Raster position
    always_comb begin
        row_end   = (r_col >= r_wlast);
        frame_end = row_end && (r_row >= r_hlast);
        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Hold the accepted request while the line stores are read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= in_acc;
        end
        if (in_acc) begin
            r_s1.judge  <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1.fend   <= frame_end;
            r_s1.row    <= r_row;
            r_s1.col    <= r_col;
            r_s1.sample <= i_in.sample_value;
        end
    end

    // Line stores: read at accept, write back in the cycle after
    lmd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_row (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1.vld),
        .i_wr_addr (r_s1.col),
        .i_wr_data (mid_rd),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (top_rd)
    );

    lmd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer_row (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1.vld),
        .i_wr_addr (r_s1.col),
        .i_wr_data (r_s1.sample),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    lmd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .i_top   (top_rd),
        .i_mid   (mid_rd),
        .o_judge (judge)
    );

    lmd_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_judge (judge),
        .o_out   (o_out),
        .o_level (level)
    );

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.vld && in_acc) |-> (r_s1.col != r_col))
        else $error("line store read and write-back hit the same column");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("raster position not cleared at frame end");

    a_judge_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.vld |=> judge.vld)
        else $error("window verdict lost");
`endif

endmodule

`default_nettype wire
